>>> design/rtx_pkg.sv
// ----------------------------------------------------------------------------
// Retransmit table package
// Shared sizes, command codes and payload types for the retransmit table.
// ----------------------------------------------------------------------------
package rtx_pkg;

  localparam int TableEntries = 8;
  localparam int IdxW         = (TableEntries > 1) ? $clog2(TableEntries) : 1;
  localparam int CntW         = $clog2(TableEntries + 1);
  localparam int DueMax       = (TableEntries > 15) ? 15 : TableEntries;

  typedef enum logic [1:0] {
    CmdAdd   = 2'd0,
    CmdTake  = 2'd1,
    CmdCount = 2'd2,
    CmdAck   = 2'd3
  } cmd_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] time_req;
    logic [15:0] uid;
    logic [7:0]  origin;
    logic [7:0]  destination;
    logic [7:0]  source;
    logic [7:0]  pkt_type;
    logic [7:0]  payload_handle;
    logic [7:0]  ack_from;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic [3:0]  due_count;
    logic [15:0] out_uid;
    logic [7:0]  out_origin;
    logic [7:0]  out_destination;
    logic [7:0]  out_source;
    logic [7:0]  out_type;
    logic [7:0]  out_handle;
  } out_item_t;

  typedef struct packed {
    logic [31:0] rx_time;
    logic [15:0] uid;
    logic [7:0]  origin;
    logic [7:0]  dest;
    logic [7:0]  source;
    logic [7:0]  ptype;
    logic [7:0]  handle;
  } entry_t;

  localparam int EntryW = $bits(entry_t);

endpackage

>>> design/retransmit_table_with_ack_unit.sv
// ----------------------------------------------------------------------------
// Retransmit table with acknowledgement
// Holds packets awaiting retransmission; add, take oldest due, count due, ack.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake               Payload
//  in        input      in_valid_i / in_stall_o  in_data_i (in_item_t)
//  out       output     out_valid_o / out_stall_i out_data_o (out_item_t)
//  cfg       input      cfg_we_i                 cfg_wdata_i (retry delay)
//
// Each command is accepted, then reads every entry in turn from the entry RAM,
// whose read is registered, and then writes back its result.
// Reset clears all valid bits at once; the entry RAM needs no clearing pass.
// A new command is accepted while a result waits; a stalled result holds the
// write-back cycle of the following command until it is transferred.
module retransmit_table_with_ack_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  rtx_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output rtx_pkg::out_item_t out_data_o,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i
);

  import rtx_pkg::*;

  localparam logic [1:0] StIdle   = 2'd0;
  localparam logic [1:0] StScan   = 2'd1;
  localparam logic [1:0] StFinish = 2'd2;

  logic [1:0]              state_q, state_d;
  logic [31:0]             retry_delay_q;
  logic [TableEntries-1:0] valid_q, valid_d;
  in_item_t                req_q;
  logic [CntW-1:0]         cnt_q, cnt_d;
  logic                    rd_vld_q;
  logic [IdxW-1:0]         proc_idx_q;
  logic                    dup_q, dup_d;
  logic                    free_found_q, free_found_d;
  logic [IdxW-1:0]         free_idx_q, free_idx_d;
  logic                    best_found_q, best_found_d;
  logic [IdxW-1:0]         best_idx_q, best_idx_d;
  entry_t                  best_q, best_d;
  logic [3:0]              ncnt_q, ncnt_d;
  logic                    hit_q, hit_d;
  logic [IdxW-1:0]         hit_idx_q, hit_idx_d;
  logic                    out_valid_q, out_valid_d;
  out_item_t               out_q, out_d;

  logic                    in_xfer;
  logic                    issue;
  logic [IdxW-1:0]         raddr;
  logic [EntryW-1:0]       rdata;
  entry_t                  ent;
  logic                    ent_live;
  logic                    ent_due;
  logic [31:0]             due_time;
  logic [32:0]             due_limit;
  logic                    res_load;
  logic                    ram_we;
  logic [IdxW-1:0]         waddr;
  entry_t                  wentry;

  assign in_xfer  = in_valid_i & ~in_stall_o;
  assign issue    = (state_q == StScan) && (cnt_q < CntW'(TableEntries));
  assign raddr    = cnt_q[IdxW-1:0];
  assign ent      = entry_t'(rdata);
  assign ent_live = rd_vld_q & valid_q[proc_idx_q];
  assign res_load = ~out_valid_q | ~out_stall_i;

  assign due_time  = (state_q == StFinish) ? best_q.rx_time : ent.rx_time;
  assign due_limit = {1'b0, due_time} + {1'b0, retry_delay_q};
  assign ent_due   = due_limit < {1'b0, req_q.time_req};

  assign wentry = '{rx_time: req_q.time_req, uid: req_q.uid, origin: req_q.origin,
                    dest: req_q.destination, source: req_q.source,
                    ptype: req_q.pkt_type, handle: req_q.payload_handle};
  assign waddr  = free_idx_q;

  rtx_ram #(
    .Width(EntryW),
    .Depth(TableEntries)
  ) u_entry_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(waddr),
    .wdata_i(wentry),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  always_comb begin
    state_d      = state_q;
    valid_d      = valid_q;
    cnt_d        = cnt_q;
    dup_d        = dup_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    best_found_d = best_found_q;
    best_idx_d   = best_idx_q;
    best_d       = best_q;
    ncnt_d       = ncnt_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    out_valid_d  = out_valid_q & out_stall_i;
    out_d        = out_q;
    ram_we       = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (in_xfer) begin
          state_d      = StScan;
          cnt_d        = '0;
          dup_d        = 1'b0;
          free_found_d = 1'b0;
          best_found_d = 1'b0;
          ncnt_d       = '0;
          hit_d        = 1'b0;
        end
      end
      StScan: begin
        if (issue) begin
          cnt_d = cnt_q + CntW'(1);
        end
        if (rd_vld_q) begin
          if (ent_live && ent.uid == req_q.uid && ent.dest == req_q.destination &&
              ent.origin == req_q.origin) begin
            dup_d = 1'b1;
          end
          if (!valid_q[proc_idx_q] && !free_found_q) begin
            free_found_d = 1'b1;
            free_idx_d   = proc_idx_q;
          end
          if (ent_live && (!best_found_q || ent.rx_time < best_q.rx_time)) begin
            best_found_d = 1'b1;
            best_idx_d   = proc_idx_q;
            best_d       = ent;
          end
          if (ent_live && ent_due && ncnt_q != 4'd15) begin
            ncnt_d = ncnt_q + 4'd1;
          end
          if (ent_live && !hit_q && ent.uid == req_q.uid &&
              ent.dest == req_q.ack_from && ent.origin == req_q.destination) begin
            hit_d     = 1'b1;
            hit_idx_d = proc_idx_q;
          end
          if (proc_idx_q == IdxW'(TableEntries - 1)) begin
            state_d = StFinish;
          end
        end
      end
      StFinish: begin
        if (res_load) begin
          state_d     = StIdle;
          out_valid_d = 1'b1;
          out_d       = '0;
          unique case (req_q.command)
            CmdAdd: begin
              if (!dup_q && free_found_q) begin
                out_d.ok            = 1'b1;
                ram_we              = 1'b1;
                valid_d[free_idx_q] = 1'b1;
              end
            end
            CmdTake: begin
              if (best_found_q && ent_due) begin
                out_d.ok              = 1'b1;
                out_d.out_uid         = best_q.uid;
                out_d.out_origin      = best_q.origin;
                out_d.out_destination = best_q.dest;
                out_d.out_source      = best_q.source;
                out_d.out_type        = best_q.ptype;
                out_d.out_handle      = best_q.handle;
                valid_d[best_idx_q]   = 1'b0;
              end
            end
            CmdCount: begin
              out_d.due_count = ncnt_q;
            end
            CmdAck: begin
              if (hit_q) begin
                out_d.ok           = 1'b1;
                valid_d[hit_idx_q] = 1'b0;
              end
            end
            default: begin
              out_d = '0;
            end
          endcase
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      retry_delay_q <= 32'd1000;
      valid_q       <= '0;
      rd_vld_q      <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      rd_vld_q    <= issue;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        retry_delay_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      req_q <= in_data_i;
    end
    cnt_q        <= cnt_d;
    proc_idx_q   <= raddr;
    dup_q        <= dup_d;
    free_found_q <= free_found_d;
    free_idx_q   <= free_idx_d;
    best_found_q <= best_found_d;
    best_idx_q   <= best_idx_d;
    best_q       <= best_d;
    ncnt_q       <= ncnt_d;
    hit_q        <= hit_d;
    hit_idx_q    <= hit_idx_d;
    out_q        <= out_d;
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_accept_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> state_q == StScan)
    else $error("accepted transfer did not start a scan");

  a_finish_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StFinish && !res_load) |=> state_q == StFinish && out_valid_q)
    else $error("result dropped while output stalled");

  a_add_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |=> valid_q[$past(waddr)])
    else $error("stored entry not marked live");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.due_count <= 4'(DueMax))
    else $error("due count exceeds table size");

endmodule

>>> design/rtx_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port and single read port with a registered read.
// ----------------------------------------------------------------------------
module rtx_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                          wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                          rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
